FILE: rtl/core/context_word_coder_core_assert.svh
// assertion macros for the context word coder core
`ifndef CONTEXT_WORD_CODER_CORE_ASSERT_SVH
`define CONTEXT_WORD_CODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define CWC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// concurrent check on the core clock and reset
`define CWC_ASSERT(lbl, prop, msg) \
  `CWC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CWC_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CWC_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/cwc_pkg.sv
// shared types and constants of the context word coder core
`default_nettype none

package cwc_pkg;

  // field widths
  localparam int unsigned SYM_W      = 4;
  localparam int unsigned CODE_W     = 26;
  localparam int unsigned ALPHA_W    = 4;
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 32;

  // arithmetic widths: weight is capped at 2^25, products grow by the 4-bit factor
  localparam int unsigned WEIGHT_W   = 26;
  localparam int unsigned PROD_W     = 30;
  localparam int unsigned SUM_W      = 31;

  localparam logic [CODE_W-1:0]   CODE_MAX   = 26'h1FF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = 26'h200_0000;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_UNKNOWN = 4'hF;

  // alphabet size limits and register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 4'd2;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 4'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 4'd4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_ORDER = 2'd1;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } cwc_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stop;
    logic out_busy;
  } cwc_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/context_word_coder_core.sv
// top level of the context word coder core
//
//  channel   dir   handshake                   payload
//  s_axis    in    s_axis_tvalid/tready        tdata[3:0] symbol, tuser seq_start
//  m_axis    out   m_axis_tvalid/tready        tdata[25:0] word_code
//  cfg       in    cfg_we_i                    cfg_idx_i, cfg_data_i
//
// an item passes through accept, k multiply-add steps and finish;
// k = earlier symbols folded in (0 .. min(context_order, MAX_ORDER)).
// the result is registered at finish, which waits while the output is busy;
// the next item is accepted once the previous one is in the output register.
// a result waiting on m_axis_tready holds the finished item in the datapath.
// reset clears the history to unknown and loads alphabet_size 4, context_order 2.
`default_nettype none

module context_word_coder_core #(
  parameter int unsigned MAX_ORDER = 7
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration write port
  input  wire                                cfg_we_i,
  input  wire  [cwc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [cwc_pkg::CFG_W-1:0]          cfg_data_i,
  // input items
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [cwc_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [3:0] symbol, [7:4] zero
  input  wire                                s_axis_tuser,   // [0] seq_start
  // result items
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [cwc_pkg::M_TDATA_W-1:0]      m_axis_tdata    // [25:0] word_code, [31:26] zero
);
  import cwc_pkg::*;

  cwc_cmd_t          cmd;
  cwc_sts_t          sts;
  logic [CODE_W-1:0] out_code;

  // sequencing
  cwc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // arithmetic and storage
  cwc_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .symbol_i    (s_axis_tdata[SYM_W-1:0]),
    .seq_start_i (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_code_o  (out_code)
  );

  // result packing
  assign m_axis_tdata = {{(M_TDATA_W-CODE_W){1'b0}}, out_code};

endmodule

`default_nettype wire

FILE: rtl/core/cwc_ctrl.sv
// controller state machine of the context word coder
`default_nettype none

`include "context_word_coder_core_assert.svh"

module cwc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  input  cwc_pkg::cwc_sts_t sts_i,
  output cwc_pkg::cwc_cmd_t cmd_o
);
  import cwc_pkg::*;

  cwc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.stop && !sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      ST_RUN: begin
        cmd_o.step   = !sts_i.stop;
        cmd_o.finish = sts_i.stop && !sts_i.out_busy;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // checks
  `CWC_ASSERT(a_ctrl_cmd_excl, $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish}), "commands overlap")
  `CWC_ASSERT(a_ctrl_fin_free, cmd_o.finish |-> !sts_i.out_busy, "finish into busy output")
  `CWC_ASSERT(a_ctrl_load_run, cmd_o.load |=> state_q == ST_RUN, "load did not start a run")

endmodule

`default_nettype wire

FILE: rtl/core/cwc_dp.sv
// datapath of the context word coder: config, history, accumulator, output register
`default_nettype none

`include "context_word_coder_core_assert.svh"

module cwc_dp #(
  parameter int unsigned MAX_ORDER = 7
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [cwc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [cwc_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire  [cwc_pkg::SYM_W-1:0]       symbol_i,
  input  wire                             seq_start_i,
  input  cwc_pkg::cwc_cmd_t               cmd_i,
  output cwc_pkg::cwc_sts_t               sts_o,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic [cwc_pkg::CODE_W-1:0]      out_code_o
);
  import cwc_pkg::*;

  localparam int unsigned IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned CntW = $clog2(MAX_ORDER + 1);

  logic [ALPHA_W-1:0]  alpha_q;
  logic [ORDER_W-1:0]  order_q;
  logic [SYM_W-1:0]    hist_q [MAX_ORDER];
  logic [SYM_W-1:0]    cur_q;
  logic [CntW-1:0]     k_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [CODE_W-1:0]   code_q;
  logic                out_valid_q;
  logic [CODE_W-1:0]   out_code_q;

  logic [ALPHA_W-1:0]  n_eff;
  logic [CntW-1:0]     eff_order;
  logic [SYM_W-1:0]    cur_dec;
  logic [SYM_W-1:0]    hist_rd;
  logic [SYM_W-1:0]    sym_p1;
  logic [PROD_W-1:0]   term;
  logic [PROD_W-1:0]   wprod;
  logic [SUM_W-1:0]    sum;
  logic [WEIGHT_W-1:0] weight_d;
  logic [CODE_W-1:0]   code_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      order_q <= ORDER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALPHABET_SIZE: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        REG_CONTEXT_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped base and order
  always_comb begin
    if (alpha_q < ALPHA_MIN) begin
      n_eff = ALPHA_MIN;
    end else if (alpha_q > ALPHA_MAX) begin
      n_eff = ALPHA_MAX;
    end else begin
      n_eff = alpha_q;
    end
    if (8'(order_q) > 8'(MAX_ORDER)) begin
      eff_order = CntW'(MAX_ORDER);
    end else begin
      eff_order = CntW'(order_q);
    end
  end

  // any negative symbol counts as unknown
  assign cur_dec = symbol_i[SYM_W-1] ? SYM_UNKNOWN : symbol_i;

  // history read at the current distance
  assign hist_rd = (k_q < CntW'(MAX_ORDER)) ? hist_q[k_q[IdxW-1:0]] : SYM_UNKNOWN;

  // stop at the order limit or at the first unknown earlier symbol
  assign sts_o.stop     = (k_q == eff_order) || hist_rd[SYM_W-1];
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // one step: code += (s + 1) * n^i, next weight n^(i+1), both saturating
  always_comb begin
    sym_p1 = hist_rd + 4'd1;
    term   = PROD_W'(sym_p1) * PROD_W'(weight_q);
    wprod  = PROD_W'(weight_q) * PROD_W'(n_eff);
    sum    = {{(SUM_W-CODE_W){code_q[CODE_W-1]}}, code_q} + {1'b0, term};
    if ($signed(sum) > $signed(SUM_W'(CODE_MAX))) begin
      code_d = CODE_MAX;
    end else begin
      code_d = sum[CODE_W-1:0];
    end
    if (wprod > PROD_W'(WEIGHT_CAP)) begin
      weight_d = WEIGHT_CAP;
    end else begin
      weight_d = wprod[WEIGHT_W-1:0];
    end
  end

  // accumulator and step counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q    <= cur_dec;
      code_q   <= {{(CODE_W-SYM_W){cur_dec[SYM_W-1]}}, cur_dec};
      weight_q <= WEIGHT_W'(n_eff);
      k_q      <= '0;
    end else if (cmd_i.step) begin
      code_q   <= code_d;
      weight_q <= weight_d;
      k_q      <= k_q + 1'b1;
    end
  end

  // history: cleared at sequence start, shifted when an item finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) hist_q[k] <= SYM_UNKNOWN;
    end else if (cmd_i.load && seq_start_i) begin
      for (int k = 0; k < MAX_ORDER; k++) hist_q[k] <= SYM_UNKNOWN;
    end else if (cmd_i.finish) begin
      for (int k = MAX_ORDER - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
      hist_q[0] <= cur_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) out_code_q <= code_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;

  // checks
  `CWC_ASSERT(a_dp_fin_valid, cmd_i.finish |=> out_valid_q, "finished item not presented")
  `CWC_ASSERT(a_dp_seq_clear, cmd_i.load && seq_start_i |=> hist_q[0] == SYM_UNKNOWN, "history not cleared")
  `CWC_ASSERT(a_dp_weight_cap, cmd_i.step |=> weight_q <= WEIGHT_CAP, "weight above cap")

endmodule

`default_nettype wire
